### rtl/core/dsf_pkg.sv
`default_nettype none
package dsf_pkg;

  typedef enum logic [1:0] {
    REG_SPRING = 2'd0,
    REG_REST   = 2'd1,
    REG_DAMP   = 2'd2
  } cfg_reg_t;

  localparam int SQRT_STAGES = 33;  // one result bit per stage, 4^32 down to 4^0
  localparam int DIV_STAGES  = 17;  // quotient bits 16..0
  localparam int MATH_STAGES = 20;
  localparam int PIPE_DEPTH  = 4 + SQRT_STAGES + DIV_STAGES + MATH_STAGES;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // Payload that rides along the root and divider stages
  typedef struct packed {
    logic [2:0]        dneg;
    logic [2:0][32:0]  dmag;
    logic [2:0][31:0]  speed;
    logic [31:0]       imass;
    logic [31:0]       dur;
    logic              zero;
  } carry_t;

  // Payload that rides along the multiply stages
  typedef struct packed {
    logic [2:0][17:0]  u;
    logic [2:0][31:0]  speed;
    logic [34:0]       dev;
    logic [63:0]       prod_mk;
    logic [63:0]       prod_cm;
    logic [31:0]       dur;
    logic              zero;
    logic              vneg;
    logic              cneg;
    logic [2:0]        tneg;
    logic [2:0]        fneg;
  } ecarry_t;

  // sat64(floor(+-prod / 2^sh))
  function automatic logic signed [63:0] shift_sat(input logic [127:0] prod,
                                                   input logic neg, input int sh);
    logic [127:0] q;
    logic [127:0] lowm;
    logic signed [63:0] res;
    q    = prod >> sh;
    lowm = (128'd1 << sh) - 128'd1;
    if (neg && ((prod & lowm) != 128'd0)) q = q + 128'd1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) res = S64_MAX;
      else res = $signed(q[63:0]);
    end else begin
      if (q >= 128'h8000_0000_0000_0000) res = S64_MIN;
      else res = -$signed(q[63:0]);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/dsf_if.sv
`default_nettype none
interface dsf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [31:0] anchor_z;
  logic signed [31:0] body_x;
  logic signed [31:0] body_y;
  logic signed [31:0] body_z;
  logic signed [31:0] speed_x;
  logic signed [31:0] speed_y;
  logic signed [31:0] speed_z;
  logic        [31:0] inverse_mass;
  logic        [31:0] step_duration;
  modport source (output valid, anchor_x, anchor_y, anchor_z, body_x, body_y, body_z,
                  speed_x, speed_y, speed_z, inverse_mass, step_duration, input ready);
  modport sink (input valid, anchor_x, anchor_y, anchor_z, body_x, body_y, body_z,
                speed_x, speed_y, speed_z, inverse_mass, step_duration, output ready);
endinterface

interface dsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic               applied;
  modport source (output valid, force_x, force_y, force_z, applied, input ready);
  modport sink (input valid, force_x, force_y, force_z, applied, output ready);
endinterface
`default_nettype wire

### rtl/core/damped_spring_force_3d.sv
`default_nettype none
// channel | dir | handshake       | word
// in_ch   | in  | valid / ready   | anchor, body, speed (x,y,z), inverse_mass, step_duration
// out_ch  | out | valid / ready   | force_x/y/z, applied
// cfg_*   | in  | cfg_we          | cfg_index selects register, cfg_data is the value
//
// The pipe has 4 front stages, a 33-stage square root (one root bit
// per stage), a 17-stage divider (one quotient bit per stage, three lanes),
// then 20 multiply/saturate stages. One word enters per cycle while in_ch.ready is high.
// The whole pipe advances on one enable; it freezes only when the output
// register holds a word that is not taken, so nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults; the data path registers are not reset.
module damped_spring_force_3d (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dsf_in_if.sink           in_ch,
  dsf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int LAST = dsf_pkg::PIPE_DEPTH - 1;

  // configuration
  logic [31:0] spring_r, rest_r, damp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_r <= 32'd65536;
      rest_r   <= 32'd655360;
      damp_r   <= 32'd0;
    end else if (cfg_we) begin
      case (dsf_pkg::cfg_reg_t'(cfg_index))
        dsf_pkg::REG_SPRING: spring_r <= cfg_data;
        dsf_pkg::REG_REST:   rest_r   <= cfg_data;
        dsf_pkg::REG_DAMP:   damp_r   <= cfg_data;
        default: ;  // no register at this index
      endcase
    end
  end

  // global pipe enable
  logic [LAST:0] vld_r;
  logic          en;

  assign en           = !vld_r[LAST] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_ch.valid};
    end
  end

  // front: offset, magnitude, squares, sum
  logic signed [2:0][32:0] d_r;
  logic [2:0][31:0]        spd0_r;
  logic [31:0]             m0_r, dur0_r;
  dsf_pkg::carry_t         c1_r, c2_r;
  logic [2:0][65:0]        sq_r;

  logic [67:0]     sq_x_r [0:dsf_pkg::SQRT_STAGES];
  logic [67:0]     sq_q_r [0:dsf_pkg::SQRT_STAGES];
  dsf_pkg::carry_t sq_c_r [0:dsf_pkg::SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: offset d = anchor - body
      d_r[0] <= {in_ch.anchor_x[31], in_ch.anchor_x} - {in_ch.body_x[31], in_ch.body_x};
      d_r[1] <= {in_ch.anchor_y[31], in_ch.anchor_y} - {in_ch.body_y[31], in_ch.body_y};
      d_r[2] <= {in_ch.anchor_z[31], in_ch.anchor_z} - {in_ch.body_z[31], in_ch.body_z};
      spd0_r <= {in_ch.speed_z, in_ch.speed_y, in_ch.speed_x};
      m0_r   <= in_ch.inverse_mass;
      dur0_r <= in_ch.step_duration;
      // stage 1: magnitudes and the coincident flag
      for (int i = 0; i < 3; i++) begin
        c1_r.dneg[i] <= d_r[i][32];
        c1_r.dmag[i] <= d_r[i][32] ? (~d_r[i] + 33'd1) : d_r[i];
      end
      c1_r.speed <= spd0_r;
      c1_r.imass <= m0_r;
      c1_r.dur   <= dur0_r;
      c1_r.zero  <= (d_r[0] == 33'sd0) && (d_r[1] == 33'sd0) && (d_r[2] == 33'sd0);
      // stage 2: squares
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 66'(c1_r.dmag[i]) * 66'(c1_r.dmag[i]);
      end
      c2_r <= c1_r;
      // stage 3: sum of squares seeds the root
      sq_x_r[0] <= 68'(sq_r[0]) + 68'(sq_r[1]) + 68'(sq_r[2]);
      sq_q_r[0] <= '0;
      sq_c_r[0] <= c2_r;
    end
  end

  // square root: bit-pair recurrence, one root bit per stage
  for (genvar k = 1; k <= dsf_pkg::SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [67:0] BIT = 68'd1 << (2 * (dsf_pkg::SQRT_STAGES - k));
    logic [67:0] trial;
    assign trial = sq_q_r[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_x_r[k-1] >= trial) begin
          sq_x_r[k] <= sq_x_r[k-1] - trial;
          sq_q_r[k] <= (sq_q_r[k-1] >> 1) + BIT;
        end else begin
          sq_x_r[k] <= sq_x_r[k-1];
          sq_q_r[k] <= sq_q_r[k-1] >> 1;
        end
        sq_c_r[k] <= sq_c_r[k-1];
      end
    end
  end

  // divider: u = (|d| << 16) / L, restoring, three lanes
  logic [2:0][49:0] dv_rem_r [1:dsf_pkg::DIV_STAGES];
  logic [2:0][16:0] dv_q_r   [1:dsf_pkg::DIV_STAGES];
  logic [32:0]      dv_l_r   [1:dsf_pkg::DIV_STAGES];
  dsf_pkg::carry_t  dv_c_r   [1:dsf_pkg::DIV_STAGES];

  for (genvar j = 1; j <= dsf_pkg::DIV_STAGES; j++) begin : g_div
    localparam int B = dsf_pkg::DIV_STAGES - j;
    logic [2:0][49:0] rem_in;
    logic [2:0][16:0] q_in;
    logic [32:0]      l_in;
    dsf_pkg::carry_t  c_in;
    logic [49:0]      dvsr;
    if (j == 1) begin : g_first
      assign l_in = sq_q_r[dsf_pkg::SQRT_STAGES][32:0];
      assign c_in = sq_c_r[dsf_pkg::SQRT_STAGES];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rem_in[i] = {1'b0, c_in.dmag[i], 16'd0};
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign l_in   = dv_l_r[j-1];
      assign c_in   = dv_c_r[j-1];
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
    end
    assign dvsr = 50'(l_in) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvsr) begin
            dv_rem_r[j][i] <= rem_in[i] - dvsr;
            dv_q_r[j][i]   <= q_in[i] | (17'd1 << B);
          end else begin
            dv_rem_r[j][i] <= rem_in[i];
            dv_q_r[j][i]   <= q_in[i];
          end
        end
        dv_l_r[j] <= l_in;
        dv_c_r[j] <= c_in;
      end
    end
  end

  // multiply and saturate stages
  dsf_pkg::ecarry_t         ec_r [1:dsf_pkg::MATH_STAGES-1];
  logic signed [2:0][49:0]  vpr_r;
  logic signed [51:0]       vsum_r;
  logic [33:0]              vmag_r;
  logic [63:0]              dp0_r, dp1_r;
  logic [65:0]              dp2_r;
  logic [127:0]             dprod_r;
  logic signed [63:0]       dmp_r;
  logic signed [63:0]       s_r;
  logic [63:0]              smag_r;
  logic [63:0]              cp00_r, cp01_r, cp10_r, cp11_r;
  logic [127:0]             cprod_r;
  logic signed [63:0]       coeff_r;
  logic [63:0]              cmag_r;
  logic [2:0][16:0]         umag_r;
  logic [2:0][48:0]         tlo_r, thi_r;
  logic [2:0][127:0]        tprod_r;
  logic [2:0][63:0]         t_r;
  logic [2:0][63:0]         tmag_r;
  logic [2:0][63:0]         flo_r, fhi_r;
  logic [2:0][127:0]        fprod_r;
  logic signed [2:0][31:0]  f_r;
  logic                     app_r;

  dsf_pkg::carry_t          dvo;
  logic [2:0][16:0]         dvq;
  logic signed [35:0]       vp;
  logic signed [65:0]       ssum;
  dsf_pkg::ecarry_t         ec_nxt [2:dsf_pkg::MATH_STAGES-1];

  assign dvo  = dv_c_r[dsf_pkg::DIV_STAGES];
  assign dvq  = dv_q_r[dsf_pkg::DIV_STAGES];
  assign vp   = 36'(vsum_r >>> 16);
  assign ssum = 66'($signed(ec_r[7].dev)) + 66'(dmp_r);

  // payload shift; sign flags join the payload at the stage that forms them
  always_comb begin
    for (int k = 2; k < dsf_pkg::MATH_STAGES; k++) ec_nxt[k] = ec_r[k-1];
    ec_nxt[4].vneg = vp[35];
    // coeff carries the opposite sign of s
    ec_nxt[9].cneg = !s_r[63] && (s_r != 64'sd0);
    for (int i = 0; i < 3; i++) begin
      ec_nxt[13].tneg[i] = ec_r[12].u[i][17] != coeff_r[63];
      ec_nxt[17].fneg[i] = t_r[i][63];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // E1: signed direction, m*k, C*m, deviation from rest
      for (int i = 0; i < 3; i++) begin
        ec_r[1].u[i] <= dvo.dneg[i] ? (18'd0 - {1'b0, dvq[i]}) : {1'b0, dvq[i]};
      end
      ec_r[1].speed   <= dvo.speed;
      ec_r[1].dev     <= {3'b000, rest_r} - {2'b00, dv_l_r[dsf_pkg::DIV_STAGES]};
      ec_r[1].prod_mk <= 64'(dvo.imass) * 64'(spring_r);
      ec_r[1].prod_cm <= 64'(damp_r) * 64'(dvo.imass);
      ec_r[1].dur     <= dvo.dur;
      ec_r[1].zero    <= dvo.zero;
      ec_r[1].vneg    <= 1'b0;
      ec_r[1].cneg    <= 1'b0;
      ec_r[1].tneg    <= '0;
      ec_r[1].fneg    <= '0;
      for (int k = 2; k < dsf_pkg::MATH_STAGES; k++) ec_r[k] <= ec_nxt[k];
      // E2: speed along the axis, per lane
      for (int i = 0; i < 3; i++) begin
        vpr_r[i] <= $signed(ec_r[1].speed[i]) * $signed(ec_r[1].u[i]);
      end
      // E3
      vsum_r <= 52'($signed(vpr_r[0])) + 52'($signed(vpr_r[1])) + 52'($signed(vpr_r[2]));
      // E4: vp = floor(vsum / 2^16), split into sign and magnitude
      vmag_r <= vp[35] ? 34'(-vp) : 34'(vp);
      // E5: damping partial products
      dp0_r <= 64'(ec_r[4].prod_cm[31:0]) * 64'(vmag_r[31:0]);
      dp1_r <= 64'(ec_r[4].prod_cm[63:32]) * 64'(vmag_r[31:0]);
      dp2_r <= 66'(ec_r[4].prod_cm) * 66'(vmag_r[33:32]);
      // E6
      dprod_r <= 128'(dp0_r) + ((128'(dp1_r) + 128'(dp2_r)) << 32);
      // E7
      dmp_r <= dsf_pkg::shift_sat(dprod_r, ec_r[6].vneg, 32);
      // E8: s = sat64(dev + damp)
      if (ssum > 66'(dsf_pkg::S64_MAX)) s_r <= dsf_pkg::S64_MAX;
      else if (ssum < 66'(dsf_pkg::S64_MIN)) s_r <= dsf_pkg::S64_MIN;
      else s_r <= ssum[63:0];
      // E9: magnitude of s
      smag_r <= s_r[63] ? 64'(-s_r) : 64'(s_r);
      // E10: P * |s| partials
      cp00_r <= 64'(ec_r[9].prod_mk[31:0])  * 64'(smag_r[31:0]);
      cp01_r <= 64'(ec_r[9].prod_mk[31:0])  * 64'(smag_r[63:32]);
      cp10_r <= 64'(ec_r[9].prod_mk[63:32]) * 64'(smag_r[31:0]);
      cp11_r <= 64'(ec_r[9].prod_mk[63:32]) * 64'(smag_r[63:32]);
      // E11
      cprod_r <= 128'(cp00_r) + ((128'(cp01_r) + 128'(cp10_r)) << 32) + (128'(cp11_r) << 64);
      // E12
      coeff_r <= dsf_pkg::shift_sat(cprod_r, ec_r[11].cneg, 32);
      // E13: magnitudes for u * coeff
      cmag_r <= coeff_r[63] ? 64'(-coeff_r) : 64'(coeff_r);
      for (int i = 0; i < 3; i++) begin
        umag_r[i] <= ec_r[12].u[i][17] ? 17'(-$signed(ec_r[12].u[i])) : ec_r[12].u[i][16:0];
      end
      for (int i = 0; i < 3; i++) begin
        // E14
        tlo_r[i] <= 49'(umag_r[i]) * 49'(cmag_r[31:0]);
        thi_r[i] <= 49'(umag_r[i]) * 49'(cmag_r[63:32]);
        // E15
        tprod_r[i] <= 128'(tlo_r[i]) + (128'(thi_r[i]) << 32);
        // E16
        t_r[i] <= dsf_pkg::shift_sat(tprod_r[i], ec_r[15].tneg[i], 16);
        // E17
        tmag_r[i] <= t_r[i][63] ? (~t_r[i] + 64'd1) : t_r[i];
        // E18
        flo_r[i] <= 64'(tmag_r[i][31:0])  * 64'(ec_r[17].dur);
        fhi_r[i] <= 64'(tmag_r[i][63:32]) * 64'(ec_r[17].dur);
        // E19
        fprod_r[i] <= 128'(flo_r[i]) + (128'(fhi_r[i]) << 32);
        // E20: output register
        f_r[i] <= ec_r[19].zero ? 32'sd0
                : dsf_pkg::clamp32(dsf_pkg::shift_sat(fprod_r[i], ec_r[19].fneg[i], 16));
      end
      app_r <= !ec_r[19].zero;
    end
  end

  assign out_ch.force_x = f_r[0];
  assign out_ch.force_y = f_r[1];
  assign out_ch.force_z = f_r[2];
  assign out_ch.applied = app_r;

endmodule
`default_nettype wire
